// ===== hdl/irct_pkg.sv =====
package irct_pkg;

    localparam int DEFAULT_MAX_FIELD_INDEX = 63;
    localparam int IDX_W = 6;

    // characters the parser keys on
    localparam logic [7:0] CH_AT     = 8'h40;  // @
    localparam logic [7:0] CH_COLON  = 8'h3A;  // :
    localparam logic [7:0] CH_SEMI   = 8'h3B;  // ;
    localparam logic [7:0] CH_SLASH  = 8'h2F;  // /
    localparam logic [7:0] CH_EQUAL  = 8'h3D;  // =
    localparam logic [7:0] CH_DASH   = 8'h2D;  // -
    localparam logic [7:0] CH_BANG   = 8'h21;  // !
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_LOW_S  = 8'h73;  // s
    localparam logic [7:0] CH_LOW_R  = 8'h72;  // r
    localparam logic [7:0] CH_LOW_N  = 8'h6E;  // n

    // result kinds
    localparam logic [3:0] K_KEY    = 4'd0;
    localparam logic [3:0] K_VALUE  = 4'd1;
    localparam logic [3:0] K_NICK   = 4'd2;
    localparam logic [3:0] K_USER   = 4'd3;
    localparam logic [3:0] K_HOST   = 4'd4;
    localparam logic [3:0] K_CMD    = 4'd5;
    localparam logic [3:0] K_MIDDLE = 4'd6;
    localparam logic [3:0] K_TRAIL  = 4'd7;
    localparam logic [3:0] K_END    = 4'd8;
    localparam logic [3:0] K_ERROR  = 4'd9;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_KEY_BYTE  = 3'd1;
    localparam logic [2:0] ERR_NO_SPACE  = 3'd2;
    localparam logic [2:0] ERR_NO_LF     = 3'd3;
    localparam logic [2:0] ERR_LINEBREAK = 3'd4;

    typedef enum logic [13:0] {
        PH_LINE       = 14'b00000000000001,
        PH_KEY        = 14'b00000000000010,
        PH_VALUE      = 14'b00000000000100,
        PH_ESC        = 14'b00000000001000,
        PH_AFTER_TAGS = 14'b00000000010000,
        PH_NICK       = 14'b00000000100000,
        PH_USER       = 14'b00000001000000,
        PH_HOST       = 14'b00000010000000,
        PH_CMD        = 14'b00000100000000,
        PH_PARAM      = 14'b00001000000000,
        PH_MIDDLE     = 14'b00010000000000,
        PH_TRAIL      = 14'b00100000000000,
        PH_WAIT_LF    = 14'b01000000000000,
        PH_SKIP       = 14'b10000000000000
    } phase_t;

    typedef struct packed {
        phase_t           phase;
        logic [IDX_W-1:0] count;
        logic             vendor;
        logic             fresh;
    } state_t;

    typedef struct packed {
        logic             valid;
        logic [3:0]       kind;
        logic [IDX_W-1:0] index;
        logic [7:0]       data;
        logic             first;
        logic [2:0]       code;
    } result_t;

    localparam state_t STATE_RESET = '{phase: PH_LINE, count: '0, vendor: 1'b0, fresh: 1'b1};

    function automatic logic is_alnum(input logic [7:0] b);
        is_alnum = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A)
                || (b >= 8'h41 && b <= 8'h5A);
    endfunction

endpackage

// ===== hdl/irc_line_tokenizer.sv =====
// Byte-serial IRC line tokenizer with IRCv3 message tags. One raw byte enters per beat on the
// s_ channel and at most one tagged byte leaves per beat on the m_ channel: tag keys and
// unescaped tag values, nick/user/host of the prefix, command, and middle or trailing
// parameters, each with a tag or parameter number (saturating at MAX_FIELD_INDEX, at most 63)
// and a first-byte flag. Delimiters produce nothing; CR LF produces an end beat; a bad byte
// produces one error beat, after which input is consumed silently up to and including LF.
// The parse state updates in the cycle the byte is taken and the result sits in the output register,
// so a byte is accepted every cycle while m_ready is high or the output register is empty. A result
// beat appears in the cycle after its input beat is accepted.
module irc_line_tokenizer #(
    parameter int MAX_FIELD_INDEX = irct_pkg::DEFAULT_MAX_FIELD_INDEX
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_field_kind,
    output logic [5:0] m_field_index,
    output logic [7:0] m_out_byte,
    output logic       m_first_of_field,
    output logic [2:0] m_error_code
);
    import irct_pkg::*;

    state_t  state_reg, state_next;
    result_t step_res;
    result_t out_reg;
    logic    m_valid_reg, m_valid_next;
    logic    accept;

    irct_step #(
        .MAX_FIELD_INDEX(MAX_FIELD_INDEX)
    ) u_step (
        .st  (state_reg),
        .b   (s_data_byte),
        .nx  (state_next),
        .res (step_res)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        if (accept) m_valid_next = step_res.valid;
        else if (m_ready) m_valid_next = 1'b0;
        else m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= STATE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && step_res.valid) out_reg <= step_res;
    end

    assign m_valid          = m_valid_reg;
    assign m_field_kind     = out_reg.kind;
    assign m_field_index    = out_reg.index;
    assign m_out_byte       = out_reg.data;
    assign m_first_of_field = out_reg.first;
    assign m_error_code     = out_reg.code;

endmodule

// ===== hdl/irct_step.sv =====
module irct_step #(
    parameter int MAX_FIELD_INDEX = irct_pkg::DEFAULT_MAX_FIELD_INDEX
) (
    input  irct_pkg::state_t  st,
    input  logic [7:0]        b,
    output irct_pkg::state_t  nx,
    output irct_pkg::result_t res
);
    import irct_pkg::*;

    localparam int IdxLimit = (MAX_FIELD_INDEX < 63) ? MAX_FIELD_INDEX : 63;

    logic             do_value;
    logic             do_cmd;
    logic             put_req;
    logic [3:0]       put_kind;
    logic [IDX_W-1:0] put_idx;
    logic [7:0]       put_data;
    logic             put_fresh;
    logic             err_req;
    logic [2:0]       err_code;
    logic             end_req;
    logic             line_reset;
    logic [IDX_W-1:0] count_bump;
    logic             is_brk;

    assign is_brk = (b == CH_CR) || (b == CH_LF);

    always_comb begin
        nx         = st;
        res        = '0;
        do_value   = 1'b0;
        do_cmd     = 1'b0;
        put_req    = 1'b0;
        put_kind   = K_KEY;
        put_idx    = '0;
        put_data   = b;
        put_fresh  = st.fresh;
        err_req    = 1'b0;
        err_code   = ERR_NONE;
        end_req    = 1'b0;
        line_reset = 1'b0;
        count_bump = (st.count < IDX_W'(IdxLimit)) ? st.count + 1'b1 : st.count;

        case (st.phase)
            PH_LINE, PH_AFTER_TAGS: begin
                if (st.phase == PH_LINE && b == CH_AT) begin
                    nx.count  = '0;
                    nx.vendor = 1'b0;
                    nx.phase  = PH_KEY;
                    nx.fresh  = 1'b1;
                end else if (b == CH_COLON) begin
                    nx.phase = PH_NICK;
                    nx.fresh = 1'b1;
                end else begin
                    nx.fresh  = 1'b1;
                    put_fresh = 1'b1;
                    do_cmd    = 1'b1;
                end
            end
            PH_KEY: begin
                if (is_alnum(b) || b == CH_DASH) begin
                    put_req  = 1'b1;
                    put_kind = K_KEY;
                    put_idx  = st.count;
                end else if (b == CH_SLASH && !st.vendor) begin
                    nx.vendor = 1'b1;
                    put_req   = 1'b1;
                    put_kind  = K_KEY;
                    put_idx   = st.count;
                end else if (b == CH_EQUAL) begin
                    nx.phase = PH_VALUE;
                    nx.fresh = 1'b1;
                end else if (is_brk) begin
                    err_req  = 1'b1;
                    err_code = ERR_LINEBREAK;
                end else begin
                    err_req  = 1'b1;
                    err_code = ERR_KEY_BYTE;
                end
            end
            PH_VALUE: do_value = 1'b1;
            PH_ESC: begin
                nx.phase = PH_VALUE;
                put_kind = K_VALUE;
                put_idx  = st.count;
                case (b)
                    CH_COLON: begin
                        put_req  = 1'b1;
                        put_data = CH_SEMI;
                    end
                    CH_LOW_S: begin
                        put_req  = 1'b1;
                        put_data = CH_SPACE;
                    end
                    CH_BSLASH: put_req = 1'b1;
                    CH_LOW_R: begin
                        put_req  = 1'b1;
                        put_data = CH_CR;
                    end
                    CH_LOW_N: begin
                        put_req  = 1'b1;
                        put_data = CH_LF;
                    end
                    CH_SPACE, CH_SEMI, CH_CR, CH_LF: do_value = 1'b1;
                    default: ;  // unknown escape is dropped
                endcase
            end
            PH_NICK, PH_USER, PH_HOST: begin
                if (st.phase == PH_NICK && b == CH_BANG) begin
                    nx.phase = PH_USER;
                    nx.fresh = 1'b1;
                end else if (st.phase != PH_HOST && b == CH_AT) begin
                    nx.phase = PH_HOST;
                    nx.fresh = 1'b1;
                end else if (b == CH_SPACE) begin
                    nx.phase = PH_CMD;
                    nx.fresh = 1'b1;
                end else if (is_brk) begin
                    err_req  = 1'b1;
                    err_code = ERR_LINEBREAK;
                end else begin
                    put_req  = 1'b1;
                    put_kind = (st.phase == PH_NICK) ? K_NICK
                             : (st.phase == PH_USER) ? K_USER : K_HOST;
                end
            end
            PH_CMD: do_cmd = 1'b1;
            PH_PARAM, PH_MIDDLE: begin
                if (st.phase == PH_PARAM && b == CH_COLON) begin
                    nx.phase = PH_TRAIL;
                    nx.fresh = 1'b1;
                end else if (b == CH_SPACE) begin
                    // two spaces in a row count an empty parameter
                    nx.count = count_bump;
                    nx.phase = PH_PARAM;
                    nx.fresh = 1'b1;
                end else if (b == CH_CR) begin
                    nx.phase = PH_WAIT_LF;
                end else if (b == CH_LF) begin
                    err_req  = 1'b1;
                    err_code = ERR_LINEBREAK;
                end else begin
                    nx.phase = PH_MIDDLE;
                    put_req  = 1'b1;
                    put_kind = K_MIDDLE;
                    put_idx  = st.count;
                end
            end
            PH_TRAIL: begin
                if (b == CH_CR) begin
                    nx.phase = PH_WAIT_LF;
                end else if (b == CH_LF) begin
                    err_req  = 1'b1;
                    err_code = ERR_LINEBREAK;
                end else begin
                    put_req  = 1'b1;
                    put_kind = K_TRAIL;
                    put_idx  = st.count;
                end
            end
            PH_WAIT_LF: begin
                if (b == CH_LF) begin
                    end_req    = 1'b1;
                    line_reset = 1'b1;
                end else begin
                    err_req  = 1'b1;
                    err_code = ERR_NO_LF;
                end
            end
            default: begin
                // skipping a bad line up to its LF
                if (b == CH_LF) line_reset = 1'b1;
                else nx.phase = PH_SKIP;
            end
        endcase

        // plain value byte, also reached from an escape before a delimiter
        if (do_value) begin
            nx.phase = PH_VALUE;
            if (b == CH_SPACE) begin
                nx.count = '0;
                nx.phase = PH_AFTER_TAGS;
                nx.fresh = 1'b1;
            end else if (b == CH_SEMI) begin
                nx.count  = count_bump;
                nx.vendor = 1'b0;
                nx.phase  = PH_KEY;
                nx.fresh  = 1'b1;
            end else if (b == CH_BSLASH) begin
                nx.phase = PH_ESC;
            end else if (is_brk) begin
                err_req  = 1'b1;
                err_code = ERR_LINEBREAK;
            end else begin
                put_req  = 1'b1;
                put_kind = K_VALUE;
                put_idx  = st.count;
                put_data = b;
            end
        end

        if (do_cmd) begin
            nx.phase = PH_CMD;
            if (is_alnum(b)) begin
                put_req  = 1'b1;
                put_kind = K_CMD;
                put_idx  = '0;
            end else if (b == CH_SPACE) begin
                nx.count = '0;
                nx.phase = PH_PARAM;
                nx.fresh = 1'b1;
            end else begin
                err_req  = 1'b1;
                err_code = ERR_NO_SPACE;
            end
        end

        if (put_req) begin
            res.valid = 1'b1;
            res.kind  = put_kind;
            res.index = put_idx;
            res.data  = put_data;
            res.first = put_fresh;
            nx.fresh  = 1'b0;
        end
        if (err_req) begin
            res.valid = 1'b1;
            res.kind  = K_ERROR;
            res.code  = err_code;
            if (b == CH_LF) line_reset = 1'b1;
            else nx.phase = PH_SKIP;
        end
        if (end_req) begin
            res.valid = 1'b1;
            res.kind  = K_END;
        end
        if (line_reset) nx = STATE_RESET;
    end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    import irct_pkg::*;

    localparam int INDEX_CAP   = (DEFAULT_MAX_FIELD_INDEX < 63) ? DEFAULT_MAX_FIELD_INDEX : 63;
    localparam int RANDOM_BYTES = 1650;
    localparam int SEGMENT_LEN  = 150;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [3:0] kind;
        logic [5:0] idx;
        logic [7:0] chr;
        logic       first_byte;
        logic [2:0] err;
    } token_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [3:0] m_field_kind;
    logic [5:0] m_field_index;
    logic [7:0] m_out_byte;
    logic       m_first_of_field;
    logic [2:0] m_error_code;

    logic [7:0] raw_bytes[$];
    token_t     expected_tokens[$];
    int         total_in = 0;
    int         beats_in = 0;
    int         mismatches = 0;
    int         cycle_count = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;

    // tokenizer state as the predictor sees it
    phase_t     tok_phase = PH_LINE;
    logic [5:0] tok_count = '0;
    logic       tok_vendor = 1'b0;
    logic       tok_fresh = 1'b1;

    irc_line_tokenizer i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_field_kind     (m_field_kind),
        .m_field_index    (m_field_index),
        .m_out_byte       (m_out_byte),
        .m_first_of_field (m_first_of_field),
        .m_error_code     (m_error_code)
    );

    always #6 aclk = ~aclk;

    function automatic bit alnum_byte(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A)
            || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic void restart_line();
        tok_phase = PH_LINE;
        tok_count = '0;
        tok_vendor = 1'b0;
        tok_fresh = 1'b1;
    endfunction

    function automatic void bump_index();
        if (tok_count < INDEX_CAP) tok_count = tok_count + 1'b1;
    endfunction

    function automatic void open_field(input phase_t ph);
        tok_phase = ph;
        tok_fresh = 1'b1;
    endfunction

    function automatic bit emit(input logic [3:0] kind, input logic [5:0] idx,
                                input logic [7:0] b, output token_t tok);
        tok = '{kind: kind, idx: idx, chr: b, first_byte: tok_fresh, err: ERR_NONE};
        tok_fresh = 1'b0;
        return 1'b1;
    endfunction

    function automatic bit emit_error(input logic [2:0] code, input logic [7:0] b,
                                      output token_t tok);
        tok = '{kind: K_ERROR, idx: '0, chr: '0, first_byte: 1'b0, err: code};
        // an error on LF has already reached the end of the line
        if (b == CH_LF) restart_line();
        else tok_phase = PH_SKIP;
        return 1'b1;
    endfunction

    function automatic bit value_char(input logic [7:0] b, output token_t tok);
        tok_phase = PH_VALUE;
        if (b == CH_SPACE) begin
            tok_count = '0;
            open_field(PH_AFTER_TAGS);
            return 1'b0;
        end
        if (b == CH_SEMI) begin
            bump_index();
            tok_vendor = 1'b0;
            open_field(PH_KEY);
            return 1'b0;
        end
        if (b == CH_BSLASH) begin
            tok_phase = PH_ESC;
            return 1'b0;
        end
        if (b == CH_CR || b == CH_LF) return emit_error(ERR_LINEBREAK, b, tok);
        return emit(K_VALUE, tok_count, b, tok);
    endfunction

    function automatic bit command_char(input logic [7:0] b, output token_t tok);
        tok_phase = PH_CMD;
        if (alnum_byte(b)) return emit(K_CMD, '0, b, tok);
        if (b == CH_SPACE) begin
            tok_count = '0;
            open_field(PH_PARAM);
            return 1'b0;
        end
        return emit_error(ERR_NO_SPACE, b, tok);
    endfunction

    // advances the parse by one byte; returns 1 when the byte yields a token
    function automatic bit tokenize(input logic [7:0] b, output token_t tok);
        tok = '0;
        case (tok_phase)
            PH_LINE: begin
                if (b == CH_AT) begin
                    tok_count = '0;
                    tok_vendor = 1'b0;
                    open_field(PH_KEY);
                    return 1'b0;
                end
                if (b == CH_COLON) begin
                    open_field(PH_NICK);
                    return 1'b0;
                end
                tok_fresh = 1'b1;
                return command_char(b, tok);
            end
            PH_KEY: begin
                if (alnum_byte(b) || b == CH_DASH) return emit(K_KEY, tok_count, b, tok);
                if (b == CH_SLASH && !tok_vendor) begin
                    tok_vendor = 1'b1;
                    return emit(K_KEY, tok_count, b, tok);
                end
                if (b == CH_EQUAL) begin
                    open_field(PH_VALUE);
                    return 1'b0;
                end
                if (b == CH_CR || b == CH_LF) return emit_error(ERR_LINEBREAK, b, tok);
                return emit_error(ERR_KEY_BYTE, b, tok);
            end
            PH_VALUE: return value_char(b, tok);
            PH_ESC: begin
                tok_phase = PH_VALUE;
                case (b)
                    CH_COLON:  return emit(K_VALUE, tok_count, CH_SEMI, tok);
                    CH_LOW_S:  return emit(K_VALUE, tok_count, CH_SPACE, tok);
                    CH_BSLASH: return emit(K_VALUE, tok_count, CH_BSLASH, tok);
                    CH_LOW_R:  return emit(K_VALUE, tok_count, CH_CR, tok);
                    CH_LOW_N:  return emit(K_VALUE, tok_count, CH_LF, tok);
                    CH_SPACE, CH_SEMI, CH_CR, CH_LF: return value_char(b, tok);
                    default:   return 1'b0;
                endcase
            end
            PH_AFTER_TAGS: begin
                if (b == CH_COLON) begin
                    open_field(PH_NICK);
                    return 1'b0;
                end
                tok_fresh = 1'b1;
                return command_char(b, tok);
            end
            PH_NICK: begin
                if (b == CH_BANG) begin
                    open_field(PH_USER);
                    return 1'b0;
                end
                if (b == CH_AT) begin
                    open_field(PH_HOST);
                    return 1'b0;
                end
                if (b == CH_SPACE) begin
                    open_field(PH_CMD);
                    return 1'b0;
                end
                if (b == CH_CR || b == CH_LF) return emit_error(ERR_LINEBREAK, b, tok);
                return emit(K_NICK, '0, b, tok);
            end
            PH_USER: begin
                if (b == CH_AT) begin
                    open_field(PH_HOST);
                    return 1'b0;
                end
                if (b == CH_SPACE) begin
                    open_field(PH_CMD);
                    return 1'b0;
                end
                if (b == CH_CR || b == CH_LF) return emit_error(ERR_LINEBREAK, b, tok);
                return emit(K_USER, '0, b, tok);
            end
            PH_HOST: begin
                if (b == CH_SPACE) begin
                    open_field(PH_CMD);
                    return 1'b0;
                end
                if (b == CH_CR || b == CH_LF) return emit_error(ERR_LINEBREAK, b, tok);
                return emit(K_HOST, '0, b, tok);
            end
            PH_CMD: return command_char(b, tok);
            PH_PARAM: begin
                if (b == CH_COLON) begin
                    open_field(PH_TRAIL);
                    return 1'b0;
                end
                // back-to-back spaces count an empty parameter
                if (b == CH_SPACE) begin
                    bump_index();
                    tok_fresh = 1'b1;
                    return 1'b0;
                end
                if (b == CH_CR) begin
                    tok_phase = PH_WAIT_LF;
                    return 1'b0;
                end
                if (b == CH_LF) return emit_error(ERR_LINEBREAK, b, tok);
                tok_phase = PH_MIDDLE;
                return emit(K_MIDDLE, tok_count, b, tok);
            end
            PH_MIDDLE: begin
                if (b == CH_SPACE) begin
                    bump_index();
                    open_field(PH_PARAM);
                    return 1'b0;
                end
                if (b == CH_CR) begin
                    tok_phase = PH_WAIT_LF;
                    return 1'b0;
                end
                if (b == CH_LF) return emit_error(ERR_LINEBREAK, b, tok);
                return emit(K_MIDDLE, tok_count, b, tok);
            end
            PH_TRAIL: begin
                if (b == CH_CR) begin
                    tok_phase = PH_WAIT_LF;
                    return 1'b0;
                end
                if (b == CH_LF) return emit_error(ERR_LINEBREAK, b, tok);
                return emit(K_TRAIL, tok_count, b, tok);
            end
            PH_WAIT_LF: begin
                if (b == CH_LF) begin
                    tok.kind = K_END;
                    restart_line();
                    return 1'b1;
                end
                return emit_error(ERR_NO_LF, b, tok);
            end
            default: begin
                if (b == CH_LF) restart_line();
                else tok_phase = PH_SKIP;
                return 1'b0;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic int idle_pct(input int segment, input bit sender);
        case (segment % 4)
            1:       return sender ? 53 : 0;
            2:       return sender ? 0 : 53;
            3:       return 38;
            default: return 0;
        endcase
    endfunction

    function automatic logic [7:0] word_char(input bit with_dash);
        int r;
        r = $urandom_range(0, with_dash ? 62 : 61);
        if (r < 10) return 8'(8'h30 + r);
        if (r < 36) return 8'(8'h61 + r - 10);
        if (r < 62) return 8'(8'h41 + r - 36);
        return CH_DASH;
    endfunction

    // any byte but CR, LF and the ones listed
    function automatic logic [7:0] text_char(input string banned);
        logic [7:0] b;
        bit clash;
        do begin
            b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(33, 126));
            clash = (b == CH_CR || b == CH_LF);
            for (int i = 0; i < banned.len(); i++) if (banned[i] == b) clash = 1'b1;
        end while (clash);
        return b;
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) raw_bytes.push_back(s[i]);
    endtask

    task automatic push_crlf();
        raw_bytes.push_back(CH_CR);
        raw_bytes.push_back(CH_LF);
    endtask

    task automatic add_message();
        string escapes;
        int n;
        int r;
        escapes = ":s\\rn";
        if ($urandom_range(0, 1) == 1) begin
            raw_bytes.push_back(CH_AT);
            if ($urandom_range(0, 15) == 0) begin
                // a key followed by a run of ';', which the parser rejects as a bad key byte
                raw_bytes.push_back(word_char(1'b0));
                repeat ($urandom_range(62, 70)) raw_bytes.push_back(CH_SEMI);
            end
            n = $urandom_range(1, 3);
            for (int t = 0; t < n; t++) begin
                if (t > 0) raw_bytes.push_back(CH_SEMI);
                repeat ($urandom_range(0, 5)) raw_bytes.push_back(word_char(1'b1));
                if ($urandom_range(0, 2) == 0) begin
                    raw_bytes.push_back(CH_SLASH);
                    repeat ($urandom_range(1, 4)) raw_bytes.push_back(word_char(1'b1));
                end
                if ($urandom_range(0, 3) != 0) begin
                    raw_bytes.push_back(CH_EQUAL);
                    repeat ($urandom_range(0, 6)) begin
                        if ($urandom_range(0, 3) == 0) begin
                            raw_bytes.push_back(CH_BSLASH);
                            r = $urandom_range(0, 6);
                            raw_bytes.push_back(r < 5 ? escapes[r] : text_char(" ;"));
                        end else begin
                            raw_bytes.push_back(text_char(" ;\\"));
                        end
                    end
                end
            end
            raw_bytes.push_back(CH_SPACE);
        end
        if ($urandom_range(0, 1) == 1) begin
            raw_bytes.push_back(CH_COLON);
            repeat ($urandom_range(0, 6)) raw_bytes.push_back(text_char(" !@"));
            if ($urandom_range(0, 1) == 1) begin
                raw_bytes.push_back(CH_BANG);
                repeat ($urandom_range(0, 5)) raw_bytes.push_back(text_char(" @"));
            end
            if ($urandom_range(0, 1) == 1) begin
                raw_bytes.push_back(CH_AT);
                repeat ($urandom_range(0, 8)) raw_bytes.push_back(text_char(" "));
            end
            raw_bytes.push_back(CH_SPACE);
        end
        repeat ($urandom_range(0, 5)) raw_bytes.push_back(word_char(1'b0));
        raw_bytes.push_back(CH_SPACE);
        if ($urandom_range(0, 15) == 0) begin
            // long run of empty parameters, often enough to saturate the parameter number
            repeat ($urandom_range(60, 70)) raw_bytes.push_back(CH_SPACE);
            raw_bytes.push_back(word_char(1'b0));
        end else begin
            n = $urandom_range(0, 3);
            for (int p = 0; p < n; p++) begin
                if (p > 0) raw_bytes.push_back(CH_SPACE);
                repeat ($urandom_range(1, 5)) raw_bytes.push_back(text_char(" :"));
            end
            if ($urandom_range(0, 1) == 1) begin
                if (n > 0) raw_bytes.push_back(CH_SPACE);
                raw_bytes.push_back(CH_COLON);
                repeat ($urandom_range(0, 8)) raw_bytes.push_back(text_char(""));
            end
        end
        push_crlf();
    endtask

    // driver: offers bytes from the pending queue and predicts each accepted beat
    always @(posedge aclk) begin
        token_t tok;
        if (!aresetn) begin
            s_valid <= 1'b0;
            restart_line();
        end else begin
            if (s_valid && s_ready) begin
                if (tokenize(s_data_byte, tok)) expected_tokens.push_back(tok);
                beats_in <= beats_in + 1;
            end
            if (!s_valid || s_ready) begin
                if (raw_bytes.size() != 0
                        && $urandom_range(0, 99) >= idle_pct(beats_in / SEGMENT_LEN, 1'b1)) begin
                    s_valid <= 1'b1;
                    s_data_byte <= raw_bytes.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result beat against the oldest predicted token
    always @(posedge aclk) begin
        token_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("unexpected result beat: field_kind %0d out_byte %0d",
                           m_field_kind, m_out_byte);
                    mismatches++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (m_field_kind !== want.kind) begin
                        $error("field_kind: expected %0d, got %0d", want.kind, m_field_kind);
                        mismatches++;
                    end
                    if (m_field_index !== want.idx) begin
                        $error("field_index: expected %0d, got %0d", want.idx, m_field_index);
                        mismatches++;
                    end
                    if (m_out_byte !== want.chr) begin
                        $error("out_byte: expected %0d, got %0d", want.chr, m_out_byte);
                        mismatches++;
                    end
                    if (m_first_of_field !== want.first_byte) begin
                        $error("first_of_field: expected %0d, got %0d",
                               want.first_byte, m_first_of_field);
                        mismatches++;
                    end
                    if (m_error_code !== want.err) begin
                        $error("error_code: expected %0d, got %0d", want.err, m_error_code);
                        mismatches++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else if (!hold_done && beats_in >= 700) begin
                // long back-pressure so the output register fills and s_ready drops
                hold_done <= 1'b1;
                hold_left <= 300;
                m_ready <= 1'b0;
            end else begin
                m_ready <= $urandom_range(0, 99) >= idle_pct(beats_in / SEGMENT_LEN, 1'b0);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int goal;
        int pick;
        int start;
        int pos;
        // tags with vendor key, escape before ';', empty key, full prefix, params
        push_text("@a/b=\\:\\;=x :n!u@h P x :t");
        push_crlf();
        // missing space where the offending byte is LF itself
        push_text("P");
        raw_bytes.push_back(CH_LF);
        // extreme bytes: error then skip to LF
        raw_bytes.push_back(8'hFF);
        raw_bytes.push_back(8'h00);
        raw_bytes.push_back(CH_LF);
        // second slash in a key
        push_text("@a/b/");
        raw_bytes.push_back(CH_LF);
        // CR not followed by LF
        push_text("P ");
        raw_bytes.push_back(CH_CR);
        push_text("x");
        raw_bytes.push_back(CH_LF);

        goal = raw_bytes.size() + RANDOM_BYTES;
        while (raw_bytes.size() < goal) begin
            start = raw_bytes.size();
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                repeat ($urandom_range(1, 8)) raw_bytes.push_back(8'($urandom_range(0, 255)));
                raw_bytes.push_back(CH_LF);
            end else begin
                add_message();
                if (pick < 32) begin
                    pos = $urandom_range(start, raw_bytes.size() - 1);
                    raw_bytes[pos] = 8'($urandom_range(0, 255));
                end
            end
        end
        total_in = raw_bytes.size();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (beats_in != total_in || expected_tokens.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== irc_line_tokenizer.f =====
hdl/irct_pkg.sv
hdl/irct_step.sv
hdl/irc_line_tokenizer.sv
test/tb_top.sv
